@@ src/hss_pkg.sv @@
// ============================================================================
// hss_pkg: shared types and constants of the hashed slot store
// Holds the transfer payload structs, the opcode codes and the command and
// status groups that join the controller to the datapath.
// ============================================================================
`default_nettype none

package hss_pkg;

   // Fixed widths of the transfer fields and the size register.
   localparam int KEY_W   = 8;
   localparam int DATA_W  = 64;
   localparam int HASH_W  = 64;
   localparam int SLOT_W  = 10;
   localparam int SIZE_W  = 11;

   localparam logic [SIZE_W-1:0] SIZE_RESET = 11'd1024;

   // Defaults for the top-level parameters.
   localparam int DEFAULT_TABLE_DEPTH = 1024;
   localparam int DEFAULT_VALUE_WIDTH = 64;

   typedef enum logic {
      OP_STORE = 1'b0,
      OP_FETCH = 1'b1
   } op_type;

   typedef struct packed {
      op_type             opcode;
      logic [KEY_W-1:0]   key_byte;
      logic               byte_present;
      logic               key_last;
      logic [DATA_W-1:0]  write_value;
   } req_type;

   typedef struct packed {
      logic [DATA_W-1:0]  read_value;
      logic [SLOT_W-1:0]  slot_index;
   } rsp_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic clear_step;   // write zero to the next slot of the clearing pass
      logic take;         // an input transfer is accepted this cycle
      logic div_step;     // one restoring-division step
      logic access;       // table write (store) or table read (fetch)
      logic out_load;     // load the result register
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic clear_last;   // the clearing pass is at its final slot
      logic div_last;     // the divider is on its final step
   } stat_type;

endpackage

`default_nettype wire

@@ src/hss_ctrl.sv @@
// ============================================================================
// hss_ctrl: controller of the hashed slot store
// Sequences the clearing pass, byte intake, the bit-serial modulo, the table
// access and the result handoff; owns the input ready and the result valid.
// ============================================================================
`default_nettype none

module hss_ctrl (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   input  wire logic              req_last,
   output logic                   req_ready,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output hss_pkg::cmd_type       cmd,
   input  wire hss_pkg::stat_type stat
);

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_DIVIDE,
      ST_ACCESS,
      ST_RESULT
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.clear_step = 1'b1;
            if (stat.clear_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_ready = 1'b1;
            cmd.take  = req_valid;
            if (req_valid && req_last) begin
               state_in = ST_DIVIDE;
            end
         end
         ST_DIVIDE: begin
            cmd.div_step = 1'b1;
            if (stat.div_last) begin
               state_in = ST_ACCESS;
            end
         end
         ST_ACCESS: begin
            cmd.access = 1'b1;
            state_in   = ST_RESULT;
         end
         ST_RESULT: begin
            // The result register is free when empty or being drained now.
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      rsp_valid_in = cmd.out_load | (rsp_valid_ff & ~rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

`default_nettype wire

@@ src/hss_dp.sv @@
// ============================================================================
// hss_dp: datapath of the hashed slot store
// Running hash, size register, bit-serial restoring divider for the modulo,
// slot table memory with its clearing counter, and the result register.
// ============================================================================
`default_nettype none

module hss_dp #(
   parameter int TABLE_DEPTH = hss_pkg::DEFAULT_TABLE_DEPTH,
   parameter int VALUE_WIDTH = hss_pkg::DEFAULT_VALUE_WIDTH
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire hss_pkg::req_type            req_data,
   input  wire logic                        csr_wr_en,
   input  wire logic [hss_pkg::SIZE_W-1:0]  csr_wr_data,
   input  wire hss_pkg::cmd_type            cmd,
   output hss_pkg::stat_type                stat,
   output hss_pkg::rsp_type                 rsp_data
);

   localparam int ADDR_W = $clog2(TABLE_DEPTH);
   localparam int DW     = $clog2(TABLE_DEPTH + 1);
   localparam int MW     = (DW > hss_pkg::SIZE_W) ? DW : hss_pkg::SIZE_W;
   localparam int CNT_W  = $clog2(hss_pkg::HASH_W);

   logic [hss_pkg::SIZE_W-1:0] size_ff;
   logic [hss_pkg::HASH_W-1:0] hash_ff, hash_upd;
   logic [hss_pkg::HASH_W-1:0] dividend_ff;
   logic [DW-1:0]              divisor_ff, eff_size, rem_ff, rem_in;
   logic [DW:0]                trial, diff;
   logic [CNT_W-1:0]           div_cnt_ff;
   logic [ADDR_W-1:0]          clr_addr_ff, slot, mem_addr;
   hss_pkg::op_type            op_ff;
   logic [VALUE_WIDTH-1:0]     wval_ff, rd_ff, mem_wdata;
   logic                       mem_we, mem_re;
   logic [MW-1:0]              size_ext;
   hss_pkg::rsp_type           rsp_ff;

   logic [VALUE_WIDTH-1:0] mem [TABLE_DEPTH];

   // Size register; zero selects one slot, oversize saturates to the depth.
   assign size_ext = MW'(size_ff);

   always_comb begin
      if (size_ff == '0) begin
         eff_size = DW'(1);
      end else if (size_ext > MW'(TABLE_DEPTH)) begin
         eff_size = DW'(TABLE_DEPTH);
      end else begin
         eff_size = DW'(size_ff);
      end
   end

   // Hash step h * 97 + byte, with 97 = 64 + 32 + 1.
   always_comb begin
      if (req_data.byte_present) begin
         hash_upd = (hash_ff << 6) + (hash_ff << 5) + hash_ff
                    + hss_pkg::HASH_W'(req_data.key_byte);
      end else begin
         hash_upd = hash_ff;
      end
   end

   // One restoring-division step: bring down the next dividend bit.
   always_comb begin
      trial = {rem_ff, dividend_ff[hss_pkg::HASH_W-1]};
      diff  = trial - (DW + 1)'(divisor_ff);
      if (trial >= (DW + 1)'(divisor_ff)) begin
         rem_in = diff[DW-1:0];
      end else begin
         rem_in = trial[DW-1:0];
      end
   end

   // The remainder is below the effective size, so it fits an address.
   assign slot = rem_ff[ADDR_W-1:0];

   assign stat.div_last   = (div_cnt_ff == CNT_W'(hss_pkg::HASH_W - 1));
   assign stat.clear_last = (clr_addr_ff == ADDR_W'(TABLE_DEPTH - 1));

   always_ff @(posedge clock) begin
      if (reset) begin
         size_ff     <= hss_pkg::SIZE_RESET;
         hash_ff     <= '0;
         clr_addr_ff <= '0;
         div_cnt_ff  <= '0;
      end else begin
         if (csr_wr_en) begin
            size_ff <= csr_wr_data;
         end
         if (cmd.clear_step) begin
            clr_addr_ff <= clr_addr_ff + ADDR_W'(1);
         end
         if (cmd.take) begin
            if (req_data.key_last) begin
               hash_ff    <= '0;
               div_cnt_ff <= '0;
            end else begin
               hash_ff <= hash_upd;
            end
         end else if (cmd.div_step) begin
            div_cnt_ff <= div_cnt_ff + CNT_W'(1);
         end
      end
   end

   // Operands captured with the final byte of a key.
   always_ff @(posedge clock) begin
      if (cmd.take && req_data.key_last) begin
         dividend_ff <= hash_upd;
         divisor_ff  <= eff_size;
         rem_ff      <= '0;
         op_ff       <= req_data.opcode;
         wval_ff     <= req_data.write_value[VALUE_WIDTH-1:0];
      end else if (cmd.div_step) begin
         dividend_ff <= {dividend_ff[hss_pkg::HASH_W-2:0], 1'b0};
         rem_ff      <= rem_in;
      end
   end

   // Slot table: one write or one read per cycle, read data registered.
   assign mem_we    = cmd.clear_step | (cmd.access & (op_ff == hss_pkg::OP_STORE));
   assign mem_re    = cmd.access & (op_ff == hss_pkg::OP_FETCH);
   assign mem_addr  = cmd.clear_step ? clr_addr_ff : slot;
   assign mem_wdata = cmd.clear_step ? '0 : wval_ff;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_addr] <= mem_wdata;
      end
      if (mem_re) begin
         rd_ff <= mem[mem_addr];
      end
   end

   // Result register.
   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         if (op_ff == hss_pkg::OP_STORE) begin
            rsp_ff.read_value <= hss_pkg::DATA_W'(wval_ff);
         end else begin
            rsp_ff.read_value <= hss_pkg::DATA_W'(rd_ff);
         end
         rsp_ff.slot_index <= hss_pkg::SLOT_W'(slot);
      end
   end

   assign rsp_data = rsp_ff;

endmodule

`default_nettype wire

@@ src/hashed_slot_store_top.sv @@
// ============================================================================
// hashed_slot_store_top: hashed table of values addressed by byte-wise keys
// Keys arrive one byte per transfer and are folded into a running 64-bit
// polynomial hash; on the last byte the hash modulo the table size picks a
// slot that is written (store) or read (fetch).
// ============================================================================
//
//   Channel   Ports                          Moves
//   -------   ----------------------------   -----------------------------------
//   request   req_valid/req_ready/req_data   one key byte, opcode, store value
//   response  rsp_valid/rsp_ready/rsp_data   slot contents or echo, slot index
//   config    csr_wr_en/csr_wr_data          table size; the user writes it only when idle, not enforced
//
// The last byte of a key starts a bit-serial restoring divider that resolves
// one hash bit per cycle; then the ACCESS state reads or writes the slot
// memory and the RESULT state loads the result register. No request is taken
// from the last byte of a key until its result is loaded. After reset a
// clearing pass writes zero into every slot, one per cycle, during which no
// request is taken. A stalled response holds the block only when the next
// key finishes before the previous result has been taken.
// ============================================================================
`default_nettype none

module hashed_slot_store_top #(
   parameter int TABLE_DEPTH = hss_pkg::DEFAULT_TABLE_DEPTH,
   parameter int VALUE_WIDTH = hss_pkg::DEFAULT_VALUE_WIDTH
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_valid,
   output logic                             req_ready,
   input  wire hss_pkg::req_type            req_data,
   output logic                             rsp_valid,
   input  wire logic                        rsp_ready,
   output hss_pkg::rsp_type                 rsp_data,
   input  wire logic                        csr_wr_en,
   input  wire logic [hss_pkg::SIZE_W-1:0]  csr_wr_data
);

   hss_pkg::cmd_type  cmd;
   hss_pkg::stat_type stat;

   // The controller decides when transfers happen; the datapath holds all
   // hash, divider, table and result storage.
   hss_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_last  (req_data.key_last),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd),
      .stat      (stat)
   );

   hss_dp #(
      .TABLE_DEPTH (TABLE_DEPTH),
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .req_data    (req_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .cmd         (cmd),
      .stat        (stat),
      .rsp_data    (rsp_data)
   );

endmodule

`default_nettype wire

@@ test/hashed_slot_store_checker.sv @@
// ============================================================================
// hashed_slot_store_checker: response predictor and scoreboard
// Watches the request, response and size-register ports of the hashed slot
// store. It keeps its own running hash, table size and mirror of the slot
// memory, queues one expected response per completed key, and compares each
// response transfer field by field.
// ============================================================================
`default_nettype none

module hashed_slot_store_checker #(
   parameter int TABLE_DEPTH = hss_pkg::DEFAULT_TABLE_DEPTH
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_valid,
   input  wire logic                        req_ready,
   input  wire hss_pkg::req_type            req_data,
   input  wire logic                        rsp_valid,
   input  wire logic                        rsp_ready,
   input  wire hss_pkg::rsp_type            rsp_data,
   input  wire logic                        csr_wr_en,
   input  wire logic [hss_pkg::SIZE_W-1:0]  csr_wr_data,
   output int                               outstanding,
   output int                               fail_count,
   output int                               checked_count
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int REPORT_LIMIT = 10;
   localparam logic [hss_pkg::HASH_W-1:0] HASH_FACTOR = 64'd97;

   logic [hss_pkg::SIZE_W-1:0] table_size;
   logic [hss_pkg::HASH_W-1:0] key_hash;
   logic [hss_pkg::DATA_W-1:0] slot_mirror [TABLE_DEPTH];
   hss_pkg::rsp_type           pending_rsp_q [$];
   int                         mismatch_total = 0;
   int                         compared_total = 0;

   assign fail_count    = mismatch_total;
   assign checked_count = compared_total;

   // Folds one request into the running hash; the last byte of a key picks
   // the slot, updates the mirror and queues the response it must produce.
   task automatic fold_request(input hss_pkg::req_type item);
      int unsigned                divisor;
      logic [hss_pkg::HASH_W-1:0] slot;
      hss_pkg::rsp_type           result;
      if (item.byte_present) begin
         key_hash = key_hash * HASH_FACTOR + hss_pkg::HASH_W'(item.key_byte);
      end
      if (item.key_last) begin
         divisor = table_size;
         if (divisor == 0) begin
            divisor = 1;
         end
         if (divisor > TABLE_DEPTH) begin
            divisor = TABLE_DEPTH;
         end
         slot = key_hash % hss_pkg::HASH_W'(divisor);
         key_hash = '0;
         if (item.opcode == hss_pkg::OP_STORE) begin
            slot_mirror[slot] = item.write_value;
            result.read_value = item.write_value;
         end else begin
            result.read_value = slot_mirror[slot];
         end
         result.slot_index = slot[hss_pkg::SLOT_W-1:0];
         pending_rsp_q.push_back(result);
      end
   endtask

   task automatic compare_response(input hss_pkg::rsp_type got);
      hss_pkg::rsp_type want;
      if (pending_rsp_q.size() == 0) begin
         mismatch_total++;
         if (mismatch_total <= REPORT_LIMIT) begin
            $display("%0t: unexpected response value=%h slot=%0d", $time,
                     got.read_value, got.slot_index);
         end
      end else begin
         want = pending_rsp_q.pop_front();
         compared_total++;
         if (got.read_value !== want.read_value ||
             got.slot_index !== want.slot_index) begin
            mismatch_total++;
            if (mismatch_total <= REPORT_LIMIT) begin
               $display("%0t: response mismatch value exp=%h act=%h slot exp=%0d act=%0d",
                        $time, want.read_value, got.read_value, want.slot_index,
                        got.slot_index);
            end
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         table_size = hss_pkg::SIZE_RESET;
         key_hash = '0;
         foreach (slot_mirror[i]) begin
            slot_mirror[i] = '0;
         end
         pending_rsp_q.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            compare_response(rsp_data);
         end
         if (req_valid && req_ready) begin
            fold_request(req_data);
         end
         if (csr_wr_en) begin
            table_size = csr_wr_data;
         end
      end
      outstanding <= pending_rsp_q.size();
   end

endmodule

`default_nettype wire

@@ test/hashed_slot_store_top_test.sv @@
// ============================================================================
// hashed_slot_store_top_test: stimulus and verdict for the hashed slot store
// Sends directed and random keys, byte by byte, under several table sizes and
// idling patterns, while a checker beside the block predicts every response.
// ============================================================================
`default_nettype none

module hashed_slot_store_top_test;
   timeunit 1ns;
   timeprecision 1ps;

   // Roughly 120 counted request transfers per phase, nine phases in all.
   localparam int ITEMS_PER_PHASE = 120;
   localparam int NUM_SIZES       = 8;
   // The quiet stretch lets any division in flight finish before a size
   // change.
   localparam int DRAIN_CYCLES    = 100;
   // The longest quiet stretch of a correct run is the clearing pass after
   // reset followed by one division; stalls are short bursts.
   // The watchdog allows many times that.
   localparam int WATCHDOG_LIMIT  = 20000;
   localparam int POOL_SIZE       = 16;
   localparam int MAX_KEY_LEN     = 12;

   logic                       clock       = 1'b0;
   logic                       reset       = 1'b1;
   logic                       req_valid   = 1'b0;
   logic                       req_ready;
   hss_pkg::req_type           req_data    = '0;
   logic                       rsp_valid;
   logic                       rsp_ready   = 1'b0;
   hss_pkg::rsp_type           rsp_data;
   logic                       csr_wr_en   = 1'b0;
   logic [hss_pkg::SIZE_W-1:0] csr_wr_data = '0;

   int outstanding;
   int fail_count;
   int checked_count;

   int send_idle_pct  = 0;
   int recv_stall_pct = 0;
   int items_sent     = 0;
   int keys_sent      = 0;
   int quiet_cycles   = 0;

   // Keys are drawn mostly from a small pool so that fetches find earlier
   // stores and small table sizes produce collisions.
   logic [hss_pkg::KEY_W-1:0] pool_bytes [POOL_SIZE][MAX_KEY_LEN];
   int                        pool_len   [POOL_SIZE];

   // Table sizes visited after the reset size: the smallest, zero (which the
   // block treats as one), all ones, two, just above the depth (which
   // saturates), a random size filled in at run time, the full depth and a
   // typical size.
   logic [hss_pkg::SIZE_W-1:0] phase_sizes [NUM_SIZES] =
      '{11'd1, 11'd0, 11'd2047, 11'd2, 11'd1025, 11'd0, 11'd1024, 11'd1000};

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   hashed_slot_store_top DUT (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   hashed_slot_store_checker checker_inst (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_data      (req_data),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_data      (rsp_data),
      .csr_wr_en     (csr_wr_en),
      .csr_wr_data   (csr_wr_data),
      .outstanding   (outstanding),
      .fail_count    (fail_count),
      .checked_count (checked_count)
   );

   // The receiver decides each cycle on its own whether to stall, so stalls
   // come in short random bursts that land on every phase of a division.
   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
   end

   // The watchdog counts cycles in which neither channel completes a
   // transfer; a hung block ends the run here.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == WATCHDOG_LIMIT) begin
         $display("Watchdog: no transfer for %0d cycles.", WATCHDOG_LIMIT);
         $display("CHECKS FAILED");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   function automatic hss_pkg::req_type make_req(input hss_pkg::op_type op,
                                                 input logic [hss_pkg::KEY_W-1:0] key_byte,
                                                 input logic present, input logic last,
                                                 input logic [hss_pkg::DATA_W-1:0] value);
      hss_pkg::req_type item;
      item.opcode       = op;
      item.key_byte     = key_byte;
      item.byte_present = present;
      item.key_last     = last;
      item.write_value  = value;
      return item;
   endfunction

   function automatic hss_pkg::op_type random_op();
      return ($urandom_range(1) == 1) ? hss_pkg::OP_FETCH : hss_pkg::OP_STORE;
   endfunction

   function automatic logic [hss_pkg::DATA_W-1:0] random_value();
      logic [hss_pkg::DATA_W-1:0] value;
      case ($urandom_range(7))
         0: value = '0;
         1: value = '1;
         default: value = {$urandom, $urandom};
      endcase
      return value;
   endfunction

   // Mostly short keys; about one in four is 6 to 12 bytes long, and the longest of these wrap the hash.
   task automatic refill_key(input int k);
      if ($urandom_range(3) == 0) begin
         pool_len[k] = $urandom_range(MAX_KEY_LEN, 6);
      end else begin
         pool_len[k] = $urandom_range(5, 0);
      end
      for (int i = 0; i < MAX_KEY_LEN; i++) begin
         pool_bytes[k][i] = hss_pkg::KEY_W'($urandom);
      end
   endtask

   // Presents one request and holds it until the transfer completes. Idle
   // cycles before it drop valid; back-to-back requests keep valid high.
   task automatic send_item(input hss_pkg::req_type item);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      @(posedge clock);
      while (!req_ready) begin
         @(posedge clock);
      end
      if (item.byte_present || item.key_last) begin
         items_sent++;
      end
      if (item.key_last) begin
         keys_sent++;
      end
   endtask

   // Stops sending and waits until the checker holds no expected response.
   // The count it reports is registered, hence the first clock.
   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) begin
         @(posedge clock);
      end
   endtask

   initial begin
      int                         phase_start;
      bit                         paused;
      int                         k;
      int                         kind;
      int                         n;
      hss_pkg::op_type            op;
      logic [hss_pkg::DATA_W-1:0] value;

      for (int i = 0; i < POOL_SIZE; i++) begin
         refill_key(i);
      end
      phase_sizes[5] = hss_pkg::SIZE_W'($urandom_range(1023, 3));

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Directed part at the reset table size. An empty key hashes to zero
      // and lands in slot 0.
      send_item(make_req(hss_pkg::OP_STORE, 8'h00, 1'b0, 1'b1, '1));
      send_item(make_req(hss_pkg::OP_FETCH, 8'hFF, 1'b0, 1'b1, '0));
      // A slot that was never stored reads the zero left by the clearing pass.
      send_item(make_req(hss_pkg::OP_FETCH, 8'h41, 1'b1, 1'b1, '1));
      // A present zero byte hashes to zero too, so it overwrites the empty
      // key's slot; the following fetch of the empty key sees the collision.
      send_item(make_req(hss_pkg::OP_STORE, 8'h00, 1'b1, 1'b1, 64'h0123_4567_89AB_CDEF));
      send_item(make_req(hss_pkg::OP_FETCH, 8'h00, 1'b0, 1'b1, '0));
      send_item(make_req(hss_pkg::OP_STORE, 8'hFF, 1'b1, 1'b1, '0));
      // Opcode and value on bytes that are not last must be ignored, as must
      // a byte that is not present.
      send_item(make_req(hss_pkg::OP_FETCH, 8'hFF, 1'b1, 1'b0, '1));
      send_item(make_req(hss_pkg::OP_STORE, 8'h5A, 1'b0, 1'b0, '1));
      send_item(make_req(hss_pkg::OP_STORE, 8'hFF, 1'b1, 1'b1, 64'h8000_0000_0000_0001));
      send_item(make_req(hss_pkg::OP_STORE, 8'hFF, 1'b1, 1'b0, '0));
      send_item(make_req(hss_pkg::OP_FETCH, 8'hFF, 1'b1, 1'b1, '0));
      // Ten bytes of all ones overflow the 64-bit hash.
      for (int i = 0; i < 10; i++) begin
         send_item(make_req((i == 9) ? hss_pkg::OP_STORE : hss_pkg::OP_FETCH, 8'hFF,
                            1'b1, i == 9, (i == 9) ? 64'hFFFF_0000_FFFF_0000 : 64'h0));
      end

      // Random phases. Each new phase changes the table size only once the
      // block is idle, then picks an idling pattern from the phase number.
      for (int phase = 0; phase <= NUM_SIZES; phase++) begin
         if (phase > 0) begin
            wait_drained();
            repeat (DRAIN_CYCLES) @(posedge clock);
            csr_wr_en   <= 1'b1;
            csr_wr_data <= phase_sizes[phase-1];
            @(posedge clock);
            csr_wr_en   <= 1'b0;
         end
         case (phase % 4)
            0: begin
               send_idle_pct  = 0;
               recv_stall_pct <= 0;
            end
            1: begin
               send_idle_pct  = 56;
               recv_stall_pct <= 0;
            end
            2: begin
               send_idle_pct  = 0;
               recv_stall_pct <= 56;
            end
            default: begin
               send_idle_pct  = 13;
               recv_stall_pct <= 13;
            end
         endcase

         phase_start = items_sent;
         paused = 1'b0;
         while (items_sent - phase_start < ITEMS_PER_PHASE) begin
            // Halfway through, the sender holds back until every response
            // of the phase so far has come back.
            if (!paused && items_sent - phase_start >= ITEMS_PER_PHASE / 2) begin
               wait_drained();
               paused = 1'b1;
            end
            kind = $urandom_range(99);
            if (kind < 15) begin
               // Noise: random fields throughout, ending on a last byte so
               // that a size change never falls inside a key.
               n = $urandom_range(4, 1);
               for (int j = 0; j < n; j++) begin
                  send_item(make_req(random_op(), hss_pkg::KEY_W'($urandom), 1'($urandom),
                                     (j == n - 1) ? 1'b1 : 1'($urandom), random_value()));
               end
            end else begin
               // A well-formed key, fresh about a third of the time, with an
               // occasional absent byte and junk opcode and value on the
               // bytes before the last.
               k = $urandom_range(POOL_SIZE - 1);
               if (kind < 40) begin
                  refill_key(k);
               end
               op = random_op();
               value = random_value();
               for (int i = 0; i < pool_len[k]; i++) begin
                  if ($urandom_range(9) == 0) begin
                     send_item(make_req(random_op(), hss_pkg::KEY_W'($urandom), 1'b0, 1'b0,
                                        random_value()));
                  end
                  if (i == pool_len[k] - 1) begin
                     send_item(make_req(op, pool_bytes[k][i], 1'b1, 1'b1, value));
                  end else begin
                     send_item(make_req(random_op(), pool_bytes[k][i], 1'b1, 1'b0,
                                        random_value()));
                  end
               end
               if (pool_len[k] == 0) begin
                  send_item(make_req(op, hss_pkg::KEY_W'($urandom), 1'b0, 1'b1, value));
               end
            end
         end
      end

      // Let every response arrive, then give a stray one time to show up.
      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Covered %0d key-byte transfers making %0d keys over %0d table sizes.",
               items_sent, keys_sent, NUM_SIZES + 1);
      $display("Compared %0d responses under mixed sender and receiver idling.",
               checked_count);
      if (fail_count == 0 && outstanding == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

`default_nettype wire

@@ sim.f @@
src/hss_pkg.sv
src/hss_ctrl.sv
src/hss_dp.sv
src/hashed_slot_store_top.sv
test/hashed_slot_store_checker.sv
test/hashed_slot_store_top_test.sv
